[rtl/kbdsc_pkg.sv]
// Shared types, constants and character tables of the keyboard scan code decoder.
package kbdsc_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] LED_CMD      = 8'hED;
    localparam logic [7:0] ACK_BYTE     = 8'hFA;
    localparam logic [7:0] RESEND_BYTE  = 8'hFE;
    localparam logic [7:0] SC_BACKSPACE = 8'h0E;
    localparam logic [7:0] SC_TAB       = 8'h0F;
    localparam logic [7:0] SC_ENTER     = 8'h1C;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
    localparam logic [7:0] SC_CAPS      = 8'h3A;
    localparam logic [7:0] SC_NUM       = 8'h45;
    localparam logic [7:0] SC_SCROLL    = 8'h46;
    localparam logic [6:0] CASE_OFFSET  = 7'h20;

    localparam logic OP_KEY_BYTE = 1'b0;
    localparam logic OP_INIT     = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] scan_byte;
    } t_in_item;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic       is_backspace;
        logic       is_enter;
        logic       is_tab;
        logic       send_valid;
        logic [7:0] send_byte;
        logic [1:0] shift_state;
        logic [2:0] lock_leds;
        logic       queue_overflow;
    } t_out_item;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic       is_backspace;
        logic       is_enter;
        logic       is_tab;
        logic [1:0] shift_next;
        logic [2:0] led_next;
        logic       led_cmd_req;
        logic       ack_seen;
        logic       resend_seen;
    } t_dec_result;

    typedef struct packed {
        logic       pop;
        logic [7:0] pop_byte;
        logic       overflow;
    } t_queue_status;

    // Unshifted character table, zero where the code gives no character.
    function automatic logic [6:0] plain_char(input logic [6:0] code);
        logic [6:0] ch;
        ch = 7'h00;
        case (code)
            7'h02: ch = 7'h31; 7'h03: ch = 7'h32; 7'h04: ch = 7'h33; 7'h05: ch = 7'h34;
            7'h06: ch = 7'h35; 7'h07: ch = 7'h36; 7'h08: ch = 7'h37; 7'h09: ch = 7'h38;
            7'h0A: ch = 7'h39; 7'h0B: ch = 7'h30; 7'h0C: ch = 7'h2D; 7'h0D: ch = 7'h5E;
            7'h10: ch = 7'h51; 7'h11: ch = 7'h57; 7'h12: ch = 7'h45; 7'h13: ch = 7'h52;
            7'h14: ch = 7'h54; 7'h15: ch = 7'h59; 7'h16: ch = 7'h55; 7'h17: ch = 7'h49;
            7'h18: ch = 7'h4F; 7'h19: ch = 7'h50; 7'h1A: ch = 7'h40; 7'h1B: ch = 7'h5B;
            7'h1E: ch = 7'h41; 7'h1F: ch = 7'h53; 7'h20: ch = 7'h44; 7'h21: ch = 7'h46;
            7'h22: ch = 7'h47; 7'h23: ch = 7'h48; 7'h24: ch = 7'h4A; 7'h25: ch = 7'h4B;
            7'h26: ch = 7'h4C; 7'h27: ch = 7'h3B; 7'h28: ch = 7'h3A; 7'h2B: ch = 7'h5D;
            7'h2C: ch = 7'h5A; 7'h2D: ch = 7'h58; 7'h2E: ch = 7'h43; 7'h2F: ch = 7'h56;
            7'h30: ch = 7'h42; 7'h31: ch = 7'h4E; 7'h32: ch = 7'h4D; 7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E; 7'h35: ch = 7'h2F; 7'h37: ch = 7'h2A; 7'h39: ch = 7'h20;
            7'h47: ch = 7'h37; 7'h48: ch = 7'h38; 7'h49: ch = 7'h39; 7'h4A: ch = 7'h2D;
            7'h4B: ch = 7'h34; 7'h4C: ch = 7'h35; 7'h4D: ch = 7'h36; 7'h4E: ch = 7'h2B;
            7'h4F: ch = 7'h31; 7'h50: ch = 7'h32; 7'h51: ch = 7'h33; 7'h52: ch = 7'h30;
            7'h53: ch = 7'h2E; 7'h73: ch = 7'h5C; 7'h7D: ch = 7'h5C;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    // Shifted character table, zero where the code gives no character.
    function automatic logic [6:0] shifted_char(input logic [6:0] code);
        logic [6:0] ch;
        ch = 7'h00;
        case (code)
            7'h02: ch = 7'h21; 7'h03: ch = 7'h22; 7'h04: ch = 7'h23; 7'h05: ch = 7'h24;
            7'h06: ch = 7'h25; 7'h07: ch = 7'h26; 7'h08: ch = 7'h27; 7'h09: ch = 7'h28;
            7'h0A: ch = 7'h29; 7'h0B: ch = 7'h7E; 7'h0C: ch = 7'h3D; 7'h0D: ch = 7'h7E;
            7'h10: ch = 7'h51; 7'h11: ch = 7'h57; 7'h12: ch = 7'h45; 7'h13: ch = 7'h52;
            7'h14: ch = 7'h54; 7'h15: ch = 7'h59; 7'h16: ch = 7'h55; 7'h17: ch = 7'h49;
            7'h18: ch = 7'h4F; 7'h19: ch = 7'h50; 7'h1A: ch = 7'h60; 7'h1B: ch = 7'h7B;
            7'h1E: ch = 7'h41; 7'h1F: ch = 7'h53; 7'h20: ch = 7'h44; 7'h21: ch = 7'h46;
            7'h22: ch = 7'h47; 7'h23: ch = 7'h48; 7'h24: ch = 7'h4A; 7'h25: ch = 7'h4B;
            7'h26: ch = 7'h4C; 7'h27: ch = 7'h2B; 7'h28: ch = 7'h2A; 7'h2B: ch = 7'h7D;
            7'h2C: ch = 7'h5A; 7'h2D: ch = 7'h58; 7'h2E: ch = 7'h43; 7'h2F: ch = 7'h56;
            7'h30: ch = 7'h42; 7'h31: ch = 7'h4E; 7'h32: ch = 7'h4D; 7'h33: ch = 7'h3C;
            7'h34: ch = 7'h3E; 7'h35: ch = 7'h3F; 7'h37: ch = 7'h2A; 7'h39: ch = 7'h20;
            7'h47: ch = 7'h37; 7'h48: ch = 7'h38; 7'h49: ch = 7'h39; 7'h4A: ch = 7'h2D;
            7'h4B: ch = 7'h34; 7'h4C: ch = 7'h35; 7'h4D: ch = 7'h36; 7'h4E: ch = 7'h2B;
            7'h4F: ch = 7'h31; 7'h50: ch = 7'h32; 7'h51: ch = 7'h33; 7'h52: ch = 7'h30;
            7'h53: ch = 7'h2E; 7'h73: ch = 7'h5F; 7'h7D: ch = 7'h7C;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

[rtl/kbdsc_decode.sv]
// Decoder for one keyboard byte: character lookup, key flags, shift and lock updates.
module kbdsc_decode (
    input  kbdsc_pkg::t_in_item    i_item,
    input  logic [1:0]             i_shift_bits,
    input  logic [2:0]             i_led_bits,
    input  logic [2:0]             i_initial_leds,
    output kbdsc_pkg::t_dec_result o_dec
);
    import kbdsc_pkg::*;

    logic [7:0] sc;
    logic       is_key;
    logic [6:0] raw_char;
    logic       is_letter;
    logic       caps_on;
    logic       shift_on;

    assign sc     = i_item.scan_byte;
    assign is_key = (i_item.opcode == OP_KEY_BYTE);

    assign raw_char  = (sc[7] == 1'b1) ? 7'h00 :
                       (i_shift_bits == 2'b00) ? plain_char(sc[6:0]) : shifted_char(sc[6:0]);
    assign is_letter = (raw_char >= 7'h41) && (raw_char <= 7'h5A);
    assign caps_on   = i_led_bits[2];
    assign shift_on  = (i_shift_bits != 2'b00);

    always_comb begin
        o_dec = '0;
        o_dec.shift_next = i_shift_bits;
        o_dec.led_next   = i_led_bits;
        if (!is_key) begin
            o_dec.led_next    = i_initial_leds;
            o_dec.led_cmd_req = 1'b1;
        end else begin
            // Letters go lower case unless exactly one of shift and caps lock is on.
            o_dec.char_code  = (is_letter && (caps_on == shift_on)) ? raw_char + CASE_OFFSET
                                                                    : raw_char;
            o_dec.char_valid = (raw_char != 7'h00);
            o_dec.is_backspace = (sc == SC_BACKSPACE);
            o_dec.is_enter     = (sc == SC_ENTER);
            o_dec.is_tab       = (sc == SC_TAB);
            unique case (sc)
                SC_LSHIFT:    o_dec.shift_next = i_shift_bits | 2'b01;
                SC_RSHIFT:    o_dec.shift_next = i_shift_bits | 2'b10;
                SC_LSHIFT_UP: o_dec.shift_next = i_shift_bits & 2'b10;
                SC_RSHIFT_UP: o_dec.shift_next = i_shift_bits & 2'b01;
                SC_CAPS: begin
                    o_dec.led_next    = i_led_bits ^ 3'b100;
                    o_dec.led_cmd_req = 1'b1;
                end
                SC_NUM: begin
                    o_dec.led_next    = i_led_bits ^ 3'b010;
                    o_dec.led_cmd_req = 1'b1;
                end
                SC_SCROLL: begin
                    o_dec.led_next    = i_led_bits ^ 3'b001;
                    o_dec.led_cmd_req = 1'b1;
                end
                ACK_BYTE:    o_dec.ack_seen    = 1'b1;
                RESEND_BYTE: o_dec.resend_seen = 1'b1;
                default: ;
            endcase
        end
    end

endmodule

[rtl/kbdsc_cmd_queue.sv]
// Command byte queue to the keyboard: up to two pushes and one pop per item.
module kbdsc_cmd_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic                     i_push_led_cmd,
    input  logic [2:0]               i_led_byte,
    input  logic                     i_pop_allowed,
    output kbdsc_pkg::t_queue_status o_status
);
    import kbdsc_pkg::*;

    logic [7:0]        r_mem [QUEUE_DEPTH];
    logic [7:0]        r_head_data;
    logic [QPTR_W-1:0] r_head, n_head;
    logic [QPTR_W-1:0] r_tail, n_tail;
    logic [QCNT_W-1:0] r_count, n_count;

    logic [QPTR_W-1:0] tail_plus1;
    logic              ok_first;
    logic              ok_second;
    logic [QCNT_W-1:0] count_after_push;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign tail_plus1 = ptr_inc(r_tail);
    assign ok_first   = i_push_led_cmd && (r_count < QCNT_W'(QUEUE_DEPTH));
    assign ok_second  = i_push_led_cmd && (r_count < QCNT_W'(QUEUE_DEPTH - 1));

    assign count_after_push = r_count + QCNT_W'(ok_first) + QCNT_W'(ok_second);

    always_comb begin
        o_status.pop      = i_pop_allowed && (count_after_push != '0);
        // An empty queue that was just pushed hands out the LED command first.
        o_status.pop_byte = (r_count != '0) ? r_head_data : LED_CMD;
        o_status.overflow = i_push_led_cmd && !ok_second;

        n_tail  = r_tail;
        if (ok_first) begin
            n_tail = tail_plus1;
        end
        if (ok_second) begin
            n_tail = ptr_inc(tail_plus1);
        end
        n_head  = o_status.pop ? ptr_inc(r_head) : r_head;
        n_count = count_after_push - QCNT_W'(o_status.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // The byte at the next head is read ahead, with the bytes pushed in this
    // step bypassed around the memory.
    always_ff @(posedge i_clk) begin
        if (i_step && ok_first) begin
            r_mem[r_tail] <= LED_CMD;
        end
        if (i_step && ok_second) begin
            r_mem[tail_plus1] <= {5'b00000, i_led_byte};
        end
        if (i_step) begin
            if (ok_second && (n_head == tail_plus1)) begin
                r_head_data <= {5'b00000, i_led_byte};
            end else if (ok_first && (n_head == r_tail)) begin
                r_head_data <= LED_CMD;
            end else begin
                r_head_data <= r_mem[n_head];
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_empty_full_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QUEUE_DEPTH)) |-> r_head == r_tail)
        else $error("pointers disagree with empty or full count");
    a_ptr_eq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) |-> (r_count == '0 || r_count == QCNT_W'(QUEUE_DEPTH)))
        else $error("equal pointers with partial count");
`endif

endmodule

[rtl/keyboard_scancode_decoder_core.sv]
// Top level of the keyboard scan code decoder with its LED command path.
// Path: an accepted item is held in the input register, decoded as it moves into the
// result register, and transfers out of the result register.
// Throughput: one item per cycle unless the output stalls; the input register and the
// result register are both refilled in the same cycle, so items flow back to back.
// Reset (synchronous, active low) clears shift, LED, answer wait and queue
// pointers, and empties both pipeline registers; the configured LEDs reset to zero.
module keyboard_scancode_decoder_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  kbdsc_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output kbdsc_pkg::t_out_item  o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_data
);
    import kbdsc_pkg::*;

    // Pipeline registers: the input register holds the item being worked on,
    // the result register holds the finished result until it is taken.
    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item, n_out_item;

    // Architectural state of the decoder.
    logic [2:0]  r_initial_leds;
    logic [1:0]  r_shift_bits;
    logic [2:0]  r_led_bits;
    logic        r_awaiting, n_awaiting;
    logic [7:0]  r_pending, n_pending;

    logic          advance;
    logic          step;
    logic          await_after;
    logic          resend;
    t_dec_result   dec;
    t_queue_status qstat;

    // The result register frees up when it is empty or being taken. The item in
    // the input register is processed in the cycle it moves into the result register.
    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    kbdsc_decode u_decode (
        .i_item         (r_in_item),
        .i_shift_bits   (r_shift_bits),
        .i_led_bits     (r_led_bits),
        .i_initial_leds (r_initial_leds),
        .o_dec          (dec)
    );

    // An ack ends the wait. A resend answer only repeats a byte that is actually
    // waiting for its answer; otherwise it is ignored.
    assign await_after = dec.ack_seen ? 1'b0 : r_awaiting;
    assign resend      = dec.resend_seen && r_awaiting;

    kbdsc_cmd_queue u_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_push_led_cmd (dec.led_cmd_req),
        .i_led_byte     (dec.led_next),
        .i_pop_allowed  (!resend && !await_after),
        .o_status       (qstat)
    );

    always_comb begin
        n_awaiting = qstat.pop ? 1'b1 : await_after;
        n_pending  = qstat.pop ? qstat.pop_byte : r_pending;

        n_out_item.char_valid     = dec.char_valid;
        n_out_item.char_code      = dec.char_code;
        n_out_item.is_backspace   = dec.is_backspace;
        n_out_item.is_enter       = dec.is_enter;
        n_out_item.is_tab         = dec.is_tab;
        n_out_item.send_valid     = resend || qstat.pop;
        n_out_item.send_byte      = resend    ? r_pending :
                                    qstat.pop ? qstat.pop_byte : 8'h00;
        n_out_item.shift_state    = dec.shift_next;
        n_out_item.lock_leds      = dec.led_next;
        n_out_item.queue_overflow = qstat.overflow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_initial_leds <= 3'b000;
            r_shift_bits   <= 2'b00;
            r_led_bits     <= 3'b000;
            r_awaiting     <= 1'b0;
            r_pending      <= 8'h00;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_initial_leds <= i_cfg_data;
            end
            if (step) begin
                r_shift_bits <= dec.shift_next;
                r_led_bits   <= dec.led_next;
                r_awaiting   <= n_awaiting;
                r_pending    <= n_pending;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (step) begin
            r_out_item <= n_out_item;
        end
    end

`ifndef SYNTHESIS
    a_send_sets_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.send_valid) |-> r_awaiting)
        else $error("byte sent without waiting for its answer");
    a_leds_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.lock_leds == r_led_bits))
        else $error("reported LEDs differ from LED state");
    a_shift_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.shift_state == r_shift_bits))
        else $error("reported shift state differs from shift state");
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed item lost from result register");
`endif

endmodule

[tb/kbd_decode_checker.sv]
// Checker for the keyboard decoder: predicts each result and compares it with the block.
`timescale 1ns / 100ps

module kbd_decode_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  kbdsc_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  kbdsc_pkg::t_out_item i_out_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [2:0]           i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    import kbdsc_pkg::*;

    // Character tables for scan code set 1, indexed by the make code.
    localparam logic [0:127][7:0] PLAIN_CHARS = {
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h5E, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h40, 8'h5B, 8'h00, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
        8'h3A, 8'h00, 8'h00, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        {24{8'h00}},
        8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00
    };

    localparam logic [0:127][7:0] SHIFTED_CHARS = {
        8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h27, 8'h28, 8'h29, 8'h7E, 8'h3D, 8'h7E, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h60, 8'h7B, 8'h00, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h2B,
        8'h2A, 8'h00, 8'h00, 8'h7D, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        {24{8'h00}},
        8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7C, 8'h00, 8'h00
    };

    logic [1:0] shift_held    = '0;
    logic [2:0] lock_bits     = '0;
    logic [2:0] init_leds     = '0;
    logic [7:0] led_cmd_fifo [$];
    bit         answer_due    = 1'b0;
    logic [7:0] last_cmd_sent = '0;
    t_out_item  expected_results [$];
    t_out_item  predicted;
    t_out_item  oldest;
    int         mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                   input logic [7:0] exp_v);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("[%0t] mismatch on %s: got 0x%02h, expected 0x%02h",
                     $time, what, got_v, exp_v);
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] got_v,
                               input logic [7:0] exp_v);
        if (got_v !== exp_v) begin
            report_mismatch(what, got_v, exp_v);
        end
    endtask

    task automatic push_cmd_byte(input logic [7:0] b, inout bit dropped);
        if (led_cmd_fifo.size() >= QUEUE_DEPTH) begin
            dropped = 1'b1;
        end else begin
            led_cmd_fifo.push_back(b);
        end
    endtask

    // Each of the two bytes is checked against the queue space on its own.
    task automatic queue_led_command(output bit dropped);
        dropped = 1'b0;
        push_cmd_byte(LED_CMD, dropped);
        push_cmd_byte({5'b0, lock_bits}, dropped);
    endtask

    task automatic predict_key_result(input t_in_item item, output t_out_item res);
        logic [7:0] code;
        logic [7:0] ch;
        logic [7:0] sent;
        bit         resend;
        bit         send;
        bit         dropped;
        code    = item.scan_byte;
        ch      = 8'h00;
        sent    = 8'h00;
        resend  = 1'b0;
        send    = 1'b0;
        dropped = 1'b0;
        if (item.opcode == OP_INIT) begin
            lock_bits = init_leds;
            queue_led_command(dropped);
        end else begin
            if (!code[7]) begin
                ch = (shift_held == 2'b00) ? PLAIN_CHARS[code[6:0]] : SHIFTED_CHARS[code[6:0]];
                // Letters come out lower case unless exactly one of shift and caps is on.
                if (ch >= 8'h41 && ch <= 8'h5A && (lock_bits[2] == (shift_held != 2'b00))) begin
                    ch = ch + 8'(CASE_OFFSET);
                end
            end
            case (code)
                SC_LSHIFT:    shift_held[0] = 1'b1;
                SC_RSHIFT:    shift_held[1] = 1'b1;
                SC_LSHIFT_UP: shift_held[0] = 1'b0;
                SC_RSHIFT_UP: shift_held[1] = 1'b0;
                SC_CAPS, SC_NUM, SC_SCROLL: begin
                    if (code == SC_CAPS) begin
                        lock_bits[2] = ~lock_bits[2];
                    end else if (code == SC_NUM) begin
                        lock_bits[1] = ~lock_bits[1];
                    end else begin
                        lock_bits[0] = ~lock_bits[0];
                    end
                    queue_led_command(dropped);
                end
                ACK_BYTE:     answer_due = 1'b0;
                RESEND_BYTE:  resend = answer_due;
                default:      ;
            endcase
        end

        if (resend) begin
            send = 1'b1;
            sent = last_cmd_sent;
        end else if (!answer_due && led_cmd_fifo.size() > 0) begin
            last_cmd_sent = led_cmd_fifo.pop_front();
            answer_due    = 1'b1;
            send          = 1'b1;
            sent          = last_cmd_sent;
        end

        res                = '0;
        res.char_valid     = (ch != 8'h00);
        res.char_code      = ch[6:0];
        res.is_backspace   = (item.opcode == OP_KEY_BYTE) && (code == SC_BACKSPACE);
        res.is_enter       = (item.opcode == OP_KEY_BYTE) && (code == SC_ENTER);
        res.is_tab         = (item.opcode == OP_KEY_BYTE) && (code == SC_TAB);
        res.send_valid     = send;
        res.send_byte      = sent;
        res.shift_state    = shift_held;
        res.lock_leds      = lock_bits;
        res.queue_overflow = dropped;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shift_held    = '0;
            lock_bits     = '0;
            init_leds     = '0;
            answer_due    = 1'b0;
            last_cmd_sent = '0;
            led_cmd_fifo.delete();
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", i_out_item.send_byte, 8'h00);
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("char_valid", 8'(i_out_item.char_valid),
                                8'(oldest.char_valid));
                    check_field("char_code", 8'(i_out_item.char_code),
                                8'(oldest.char_code));
                    check_field("is_backspace", 8'(i_out_item.is_backspace),
                                8'(oldest.is_backspace));
                    check_field("is_enter", 8'(i_out_item.is_enter),
                                8'(oldest.is_enter));
                    check_field("is_tab", 8'(i_out_item.is_tab), 8'(oldest.is_tab));
                    check_field("send_valid", 8'(i_out_item.send_valid),
                                8'(oldest.send_valid));
                    check_field("send_byte", i_out_item.send_byte, oldest.send_byte);
                    check_field("shift_state", 8'(i_out_item.shift_state),
                                8'(oldest.shift_state));
                    check_field("lock_leds", 8'(i_out_item.lock_leds),
                                8'(oldest.lock_leds));
                    check_field("queue_overflow", 8'(i_out_item.queue_overflow),
                                8'(oldest.queue_overflow));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                init_leds = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_key_result(i_in_item, predicted);
                expected_results.push_back(predicted);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatch_count;
    end

endmodule

[tb/testbench.sv]
// Top of the keyboard decoder testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps

module testbench;
    import kbdsc_pkg::*;

    // Generous bound on the whole run; the slowest legal run needs far fewer cycles.
    localparam int CYCLE_LIMIT = 1000000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_data  = '0;

    int         fail_count;
    int         pending;
    int         cycle_count = 0;
    int         items_sent  = 0;
    int         burst_left  = 0;
    int         stall_left  = 0;
    bit         stalling    = 1'b0;
    int         phase;
    logic [2:0] phase_leds;

    always #10 clk = ~clk;

    keyboard_scancode_decoder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    kbd_decode_checker decode_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Any run that goes past the limit has hung somewhere, so it fails.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Length of one idle stretch: mostly short, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end
        if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // The result side alternates between stall stretches and free stretches. Some free
    // stretches are long, so results also flow back to back for a while.
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stalling = !stalling;
            if (stalling) begin
                stall_left = idle_length();
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(30, 90);
            end else begin
                stall_left = $urandom_range(1, 6);
            end
        end
        stall_left = stall_left - 1;
        out_stall <= stalling;
    end

    // Offers one item at the falling edge and holds it until the transfer happens. Valid
    // stays high into the next item when no gap follows, so it is never dropped and
    // raised again in the same step.
    task automatic send_key(input logic op, input logic [7:0] code);
        int gap;
        int r;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= '{opcode: op, scan_byte: code};
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                burst_left = $urandom_range(20, 80);
                gap = 0;
            end else if (r < 55) begin
                gap = 0;
            end else begin
                gap = idle_length();
            end
        end
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stops offering items and waits until every predicted result has been seen. Extra
    // waiting after that covers the two-stage path through the block.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // The LED preset is changed only while the block holds no work.
    task automatic write_initial_leds(input logic [2:0] leds);
        wait_for_drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= leds;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Keyboard answer to a command byte: mostly an ack, sometimes a resend request.
    task automatic send_keyboard_answer();
        if ($urandom_range(0, 9) < 7) begin
            send_key(OP_KEY_BYTE, ACK_BYTE);
        end else begin
            send_key(OP_KEY_BYTE, RESEND_BYTE);
        end
    endtask

    function automatic logic [7:0] random_lock_key();
        case ($urandom_range(0, 2))
            0:       return SC_CAPS;
            1:       return SC_NUM;
            default: return SC_SCROLL;
        endcase
    endfunction

    // Random traffic built mostly from realistic sequences: typing inside shift presses,
    // lock keys answered by the keyboard, bare answers, init requests, and bursts of lock
    // keys that fill the command queue. Also raw noise, drain waits and unreleased shifts.
    task automatic run_random_phase(input int count);
        int         stop_at;
        int         kind;
        int         len;
        int         i;
        logic [1:0] held;
        logic [7:0] code;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                held = 2'($urandom_range(0, 3));
                if (held[0]) begin
                    send_key(OP_KEY_BYTE, SC_LSHIFT);
                end
                if (held[1]) begin
                    send_key(OP_KEY_BYTE, SC_RSHIFT);
                end
                len = $urandom_range(2, 8);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        code = 8'($urandom_range(0, 127));
                    end else begin
                        code = 8'($urandom_range(8'h02, 8'h39));
                    end
                    send_key(OP_KEY_BYTE, code);
                end
                // Now and then a shift key is left held down.
                if (held[0] && $urandom_range(0, 9) != 0) begin
                    send_key(OP_KEY_BYTE, SC_LSHIFT_UP);
                end
                if (held[1] && $urandom_range(0, 9) != 0) begin
                    send_key(OP_KEY_BYTE, SC_RSHIFT_UP);
                end
            end else if (kind < 55) begin
                send_key(OP_KEY_BYTE, random_lock_key());
                len = $urandom_range(1, 3);
                for (i = 0; i < len; i++) begin
                    send_keyboard_answer();
                end
            end else if (kind < 72) begin
                len = $urandom_range(1, 3);
                for (i = 0; i < len; i++) begin
                    send_keyboard_answer();
                end
            end else if (kind < 77) begin
                send_key(OP_INIT, 8'($urandom_range(0, 255)));
                send_keyboard_answer();
            end else if (kind < 90) begin
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++) begin
                    send_key($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
                end
            end else if (kind < 98) begin
                // Lock keys with hardly any acks overrun the command queue; a long run
                // of answers then drains it again.
                len = $urandom_range(14, 22);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_key(OP_KEY_BYTE, ACK_BYTE);
                    end else begin
                        send_key(OP_KEY_BYTE, random_lock_key());
                    end
                end
                for (i = 0; i < 40; i++) begin
                    send_keyboard_answer();
                end
            end else begin
                wait_for_drain();
            end
        end
    endtask

    initial begin
        // Synchronous reset held low from time zero, released at a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with caps and scroll preset.
        write_initial_leds(3'b101);
        send_key(OP_INIT, 8'hFF);               // init ignores the byte it carries
        send_key(OP_KEY_BYTE, RESEND_BYTE);     // resend of the waiting command byte
        send_key(OP_KEY_BYTE, ACK_BYTE);        // ack sends the LED byte next
        send_key(OP_KEY_BYTE, ACK_BYTE);        // queue now empty
        send_key(OP_KEY_BYTE, RESEND_BYTE);     // resend with nothing waiting
        send_key(OP_KEY_BYTE, ACK_BYTE);        // ack with nothing waiting
        send_key(OP_KEY_BYTE, 8'h00);
        send_key(OP_KEY_BYTE, 8'h7F);
        send_key(OP_KEY_BYTE, 8'h80);
        send_key(OP_KEY_BYTE, 8'hFF);
        send_key(OP_KEY_BYTE, 8'h1E);           // letter with caps on
        send_key(OP_KEY_BYTE, SC_CAPS);
        send_key(OP_KEY_BYTE, ACK_BYTE);
        send_key(OP_KEY_BYTE, 8'h1E);           // letter with caps off
        send_key(OP_KEY_BYTE, SC_LSHIFT);
        send_key(OP_KEY_BYTE, 8'h1E);           // shifted letter
        send_key(OP_KEY_BYTE, SC_RSHIFT);
        send_key(OP_KEY_BYTE, SC_LSHIFT_UP);
        send_key(OP_KEY_BYTE, 8'h0B);           // shifted digit row
        send_key(OP_KEY_BYTE, SC_RSHIFT_UP);
        send_key(OP_KEY_BYTE, SC_NUM);
        send_key(OP_KEY_BYTE, SC_SCROLL);
        send_key(OP_KEY_BYTE, SC_BACKSPACE);
        send_key(OP_KEY_BYTE, SC_ENTER);
        send_key(OP_KEY_BYTE, SC_TAB);
        send_key(OP_KEY_BYTE, 8'h73);
        send_key(OP_KEY_BYTE, 8'h7D);

        // Random phases, each with its own LED preset, the extremes among them.
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       phase_leds = 3'b111;
                1:       phase_leds = 3'b000;
                2:       phase_leds = 3'b010;
                3:       phase_leds = 3'b100;
                default: phase_leds = 3'($urandom_range(0, 7));
            endcase
            write_initial_leds(phase_leds);
            send_key(OP_INIT, 8'($urandom_range(0, 255)));
            run_random_phase(245);
        end

        wait_for_drain();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/kbdsc_pkg.sv
rtl/kbdsc_decode.sv
rtl/kbdsc_cmd_queue.sv
rtl/keyboard_scancode_decoder_core.sv
tb/kbd_decode_checker.sv
tb/testbench.sv
